// ===== rtl/node_snap_table_macros.svh =====
// ----------------------------------------------------------------------------
// node snap table assertion macros
// concurrent checks on clk with the asynchronous reset as disable
// ----------------------------------------------------------------------------
`ifndef NODE_SNAP_TABLE_MACROS_SVH
`define NODE_SNAP_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define NST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be true outside reset
`define NST_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define NST_ASSERT(lbl, prop, msg)
`define NST_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/nst_pkg.sv =====
// ----------------------------------------------------------------------------
// node snap table package
// codes, sequencer states and default sizes shared by the block
// ----------------------------------------------------------------------------
package nst_pkg;

	localparam int DEF_MAX_NODES  = 1024;
	localparam int DEF_COORD_BITS = 24;

	localparam int RADIUS_BITS = 23;
	localparam int RSQ_BITS    = 2 * RADIUS_BITS;
	localparam int INDEX_BITS  = 10;
	localparam int COUNT_BITS  = 11;

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 23'd100;

	typedef enum logic [1:0] {
		ACT_FIND    = 2'd0,
		ACT_NEAREST = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_MATCHED = 2'd0,
		STS_CREATED = 2'd1,
		STS_NONE    = 2'd2,
		STS_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_DRAIN,
		SEQ_FINISH
	} seq_state_t;

endpackage

// ===== rtl/nst_dist.sv =====
// ----------------------------------------------------------------------------
// node snap table distance unit
// three stage squared euclidean distance, one node per cycle
// ----------------------------------------------------------------------------
module nst_dist #(
	parameter int COORD_BITS = 24,
	parameter int IDX_W      = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic [IDX_W-1:0]        in_idx,
	input  logic [3*COORD_BITS-1:0] node_pos,   // x, y, z from the lowest bit up
	input  logic [3*COORD_BITS-1:0] query_pos,  // x, y, z from the lowest bit up
	output logic                    out_vld,
	output logic [IDX_W-1:0]        out_idx,
	output logic [2*COORD_BITS+1:0] out_dist,
	output logic                    busy
);

	localparam int CB     = COORD_BITS;
	localparam int SQ_W   = 2 * CB;
	localparam int DIST_W = 2 * CB + 2;

	logic              vld_s1, vld_s2, vld_s3;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3;
	logic [CB-1:0]     mag_d [3];
	logic [CB-1:0]     mag_s1 [3];
	logic [SQ_W-1:0]   sq_s2 [3];
	logic [DIST_W-1:0] dist_s3;

	// absolute coordinate differences
	always_comb begin
		logic signed [CB:0] diff;
		logic [CB:0]        mag_full;
		for (int a = 0; a < 3; a++) begin
			diff = $signed({node_pos[a*CB+CB-1], node_pos[a*CB +: CB]})
				- $signed({query_pos[a*CB+CB-1], query_pos[a*CB +: CB]});
			mag_full = diff[CB] ? (~diff + 1'b1) : diff;
			mag_d[a] = mag_full[CB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= in_idx;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		for (int a = 0; a < 3; a++) begin
			mag_s1[a] <= mag_d[a];
			sq_s2[a]  <= SQ_W'(mag_s1[a]) * SQ_W'(mag_s1[a]);
		end
		dist_s3 <= DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);
	end

	assign out_vld  = vld_s3;
	assign out_idx  = idx_s3;
	assign out_dist = dist_s3;
	assign busy     = vld_s1 | vld_s2 | vld_s3;

endmodule

// ===== rtl/node_snap_table.sv =====
// ----------------------------------------------------------------------------
// node snap table
// table of 3-d node positions with snap-or-create and nearest node queries
// ----------------------------------------------------------------------------
// flow: find or nearest on a non-empty table scans all n stored nodes, drains the
//   distance unit and then finishes; clear, unused action or any query on an empty
//   table goes straight to finish; a stalled result side holds it in finish
// throughput: one request at a time, set by the node memory read port and the
//   distance unit that visit one stored node per cycle
// reset: node count 0, snap radius 100, output empty; node storage is not cleared
`include "node_snap_table_macros.svh"

module node_snap_table import nst_pkg::*; #(
	parameter int MAX_NODES  = DEF_MAX_NODES,
	parameter int COORD_BITS = DEF_COORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// snap radius register
	input  logic                                 cfg_wr_en,
	input  logic [RADIUS_BITS-1:0]               cfg_wr_data,
	// request channel
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,   // pos_x, pos_y, pos_z
	input  logic [1:0]                           s_tuser,   // action
	// result channel
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [23:0]                          m_tdata,   // node_index, node_count
	output logic [1:0]                           m_tuser    // status
);

	localparam int CB        = COORD_BITS;
	localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W     = $clog2(MAX_NODES + 1);
	localparam int DIST_BITS = 2 * CB + 2;
	localparam int BEST_BITS = (DIST_BITS > RSQ_BITS) ? DIST_BITS : RSQ_BITS;
	localparam int TDATA_W   = ((3*CB+7)/8)*8;

	// sequencer and request registers
	seq_state_t             state_q, state_d;
	action_t                act_q, in_act;
	logic [CB-1:0]          qx_q, qy_q, qz_q;
	logic [CNT_W-1:0]       count_q;
	logic [RADIUS_BITS-1:0] snap_radius_q;

	// scan address and node memory
	logic [IDX_W-1:0]       rd_addr_q;
	logic                   rd_en;
	logic                   scan_last;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [3*CB-1:0]        rd_data_s1;
	logic [3*CB-1:0]        node_mem [MAX_NODES];
	logic                   mem_we;
	logic                   create;

	// distance unit and running best
	logic                   dist_vld;
	logic [IDX_W-1:0]       dist_idx;
	logic [DIST_BITS-1:0]   dist_val;
	logic                   dist_busy;
	logic [BEST_BITS-1:0]   dist_ext;
	logic [BEST_BITS-1:0]   best_q;
	logic [IDX_W-1:0]       best_idx_q;
	logic                   found_q;
	logic                   take;

	// result
	logic                   out_load;
	logic [IDX_W-1:0]       res_idx;
	status_t                res_sts;
	logic [CNT_W-1:0]       res_cnt;
	logic                   m_tvalid_q;
	logic [23:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	logic                   accept;

	assign in_act    = action_t'(s_tuser);
	assign accept    = s_tvalid && s_tready;
	assign scan_last = (CNT_W'(rd_addr_q) == count_q - CNT_W'(1));

	// find keeps the later node on equal distance, nearest keeps the earlier one
	assign dist_ext = BEST_BITS'(dist_val);
	assign take     = (act_q == ACT_FIND) ? (dist_ext <= best_q)
		: (!found_q || dist_ext < best_q);

	// ------------------------------------------------------------------------
	// sequencer: idle -> finish directly, or idle -> scan (one node read per cycle) -> drain -> finish
	// ------------------------------------------------------------------------
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		mem_we   = 1'b0;
		create   = 1'b0;
		res_idx  = '0;
		res_sts  = STS_NONE;
		res_cnt  = count_q;
		unique case (state_q)
			SEQ_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if ((in_act == ACT_FIND || in_act == ACT_NEAREST) && count_q != '0)
						state_d = SEQ_SCAN;
					else
						state_d = SEQ_FINISH;
				end
			end
			SEQ_SCAN: begin
				rd_en = 1'b1;
				if (scan_last)
					state_d = SEQ_DRAIN;
			end
			SEQ_DRAIN: begin
				// the last compare lands the cycle the distance pipe goes empty
				if (!rd_vld_s1 && !dist_busy)
					state_d = SEQ_FINISH;
			end
			SEQ_FINISH: begin
				unique case (act_q)
					ACT_FIND: begin
						if (found_q) begin
							res_idx = best_idx_q;
							res_sts = STS_MATCHED;
						end else if (count_q != CNT_W'(MAX_NODES)) begin
							// append the query as a new node
							create  = 1'b1;
							res_idx = count_q[IDX_W-1:0];
							res_sts = STS_CREATED;
							res_cnt = count_q + CNT_W'(1);
						end else begin
							res_sts = STS_FULL;
						end
					end
					ACT_NEAREST: begin
						if (found_q) begin
							res_idx = best_idx_q;
							res_sts = STS_MATCHED;
						end
					end
					ACT_CLEAR: begin
						res_cnt = '0;
					end
					ACT_NONE: begin
						res_cnt = count_q;
					end
				endcase
				// output register parts the sides; wait only while it is still full
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					mem_we   = create;
					state_d  = SEQ_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= SEQ_IDLE;
			count_q       <= '0;
			snap_radius_q <= RADIUS_RESET;
			m_tvalid_q    <= 1'b0;
			rd_vld_s1     <= 1'b0;
			found_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (cfg_wr_en)
				snap_radius_q <= cfg_wr_data;
			if (accept)
				found_q <= 1'b0;
			else if (dist_vld && take)
				found_q <= 1'b1;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				count_q    <= res_cnt;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request capture, scan address, running best and result data
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= in_act;
			qx_q       <= s_tdata[CB-1:0];
			qy_q       <= s_tdata[2*CB-1:CB];
			qz_q       <= s_tdata[3*CB-1:2*CB];
			rd_addr_q  <= '0;
			best_idx_q <= '0;
			// find starts from the squared snap radius, nearest from nothing
			if (in_act == ACT_FIND)
				best_q <= BEST_BITS'(RSQ_BITS'(snap_radius_q) * RSQ_BITS'(snap_radius_q));
			else
				best_q <= '0;
		end else begin
			if (rd_en)
				rd_addr_q <= rd_addr_q + IDX_W'(1);
			if (dist_vld && take) begin
				best_q     <= dist_ext;
				best_idx_q <= dist_idx;
			end
		end
		if (out_load) begin
			m_tdata_q <= {3'b000, COUNT_BITS'(res_cnt), INDEX_BITS'(res_idx)};
			m_tuser_q <= res_sts;
		end
	end

	// node memory: one write port for appends, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (mem_we)
			node_mem[count_q[IDX_W-1:0]] <= {qz_q, qy_q, qx_q};
		if (rd_en) begin
			rd_data_s1 <= node_mem[rd_addr_q];
			rd_idx_s1  <= rd_addr_q;
		end
	end

	nst_dist #(
		.COORD_BITS (COORD_BITS),
		.IDX_W      (IDX_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (rd_vld_s1),
		.in_idx    (rd_idx_s1),
		.node_pos  (rd_data_s1),
		.query_pos ({qz_q, qy_q, qx_q}),
		.out_vld   (dist_vld),
		.out_idx   (dist_idx),
		.out_dist  (dist_val),
		.busy      (dist_busy)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// bits of s_tdata above the three coordinates are padding
	logic unused_pad;
	assign unused_pad = (TDATA_W > 3*CB) ? ^s_tdata : 1'b0;

	`NST_ASSERT(a_finish_drained, (state_q == SEQ_FINISH && $past(state_q) == SEQ_DRAIN) |-> !dist_busy, "finish reached with distances in flight")
	`NST_ASSERT(a_result_from_finish, $rose(m_tvalid_q) |-> $past(state_q) == SEQ_FINISH, "result shown outside finish")
	`NST_ASSERT(a_append_not_full, mem_we |-> count_q != CNT_W'(MAX_NODES), "append into a full table")
	`NST_ASSERT(a_dist_in_scan, dist_vld |-> (state_q == SEQ_SCAN || state_q == SEQ_DRAIN), "distance outside a scan")

endmodule

// ===== test/tb_node_snap_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node snap table testbench
// drives find, nearest, clear and unused-action requests through the request
// stream and checks every result against an in-bench table model. runs a
// directed pass and clustered random phases with several snap radii. both
// stream sides stall at random except in the closing stretch
// ----------------------------------------------------------------------------
module tb_node_snap_table;
	import nst_pkg::*;

	localparam int MAX_NODES    = DEF_MAX_NODES;
	localparam int COORD_BITS   = DEF_COORD_BITS;
	localparam int TDATA_W      = ((3*COORD_BITS+7)/8)*8;
	localparam int RANDOM_ITEMS = 554;
	// the last stretch of the random part runs with no stalls on either side
	localparam int QUIET_ITEMS  = 60;
	// slowest run: about 600 requests, each a full scan plus the longest gap
	// and the longest stall, taken several times over
	localparam longint CYCLE_LIMIT = 64'd8_000_000;
	localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = '1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct {
		logic [INDEX_BITS-1:0] index;
		status_t               status;
		logic [COUNT_BITS-1:0] count;
	} snap_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [RADIUS_BITS-1:0] cfg_wr_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_W-1:0]     s_tdata;   // pos_x, pos_y, pos_z
	logic [1:0]             s_tuser;   // action
	logic                   m_tvalid;
	logic                   m_tready;
	logic [23:0]            m_tdata;   // node_index, node_count
	logic [1:0]             m_tuser;   // status

	node_snap_table #(
		.MAX_NODES (MAX_NODES),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// bench copy of the node table and the snap radius
	coord_t                 tbl_x [MAX_NODES];
	coord_t                 tbl_y [MAX_NODES];
	coord_t                 tbl_z [MAX_NODES];
	int unsigned            tbl_count = 0;
	logic [RADIUS_BITS-1:0] radius_q  = RADIUS_RESET;

	// results owed by the block, oldest first
	snap_result_t pending_results[$];
	int unsigned  err_count = 0;
	// set in the closing stretch: no stalls on either side
	bit           quiet = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin : watchdog
		longint cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("*** FAILED ***");
		$finish;
	end

	// squared distance from stored node i to the query, never overflows at 24 bits
	function automatic longint unsigned dist_to_node(int unsigned i, coord_t x, coord_t y,
		coord_t z);
		longint dx, dy, dz;
		dx = longint'(tbl_x[i]) - longint'(x);
		dy = longint'(tbl_y[i]) - longint'(y);
		dz = longint'(tbl_z[i]) - longint'(z);
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// applies one request to the bench table and gives the result it must produce
	function automatic snap_result_t snap_predict(action_t act, coord_t x, coord_t y,
		coord_t z);
		snap_result_t     res;
		longint unsigned  best, d;
		bit               found;
		res.index  = '0;
		res.status = STS_NONE;
		found      = 1'b0;
		best       = 0;
		case (act)
			ACT_FIND: begin
				best = radius_q;
				best = best * best;
				// at or inside the radius, later nodes win ties
				for (int unsigned i = 0; i < tbl_count; i++) begin
					d = dist_to_node(i, x, y, z);
					if (d <= best) begin
						best      = d;
						res.index = INDEX_BITS'(i);
						found     = 1'b1;
					end
				end
				if (found) begin
					res.status = STS_MATCHED;
				end else if (tbl_count < MAX_NODES) begin
					tbl_x[tbl_count] = x;
					tbl_y[tbl_count] = y;
					tbl_z[tbl_count] = z;
					res.index  = INDEX_BITS'(tbl_count);
					res.status = STS_CREATED;
					tbl_count++;
				end else begin
					res.status = STS_FULL;
				end
			end
			ACT_NEAREST: begin
				// strict minimum, earlier nodes win ties
				for (int unsigned i = 0; i < tbl_count; i++) begin
					d = dist_to_node(i, x, y, z);
					if (!found || d < best) begin
						best      = d;
						res.index = INDEX_BITS'(i);
						found     = 1'b1;
					end
				end
				if (found)
					res.status = STS_MATCHED;
			end
			ACT_CLEAR: begin
				tbl_count = 0;
			end
			default: ;
		endcase
		res.count = COUNT_BITS'(tbl_count);
		return res;
	endfunction

	// result side: random stalls until the closing stretch
	initial begin
		forever begin
			if (quiet || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	// every accepted result is checked against the oldest owed result
	always @(posedge clk) begin : result_check
		snap_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with none owed, index %0d status %0d count %0d",
					$time, m_tdata[9:0], m_tuser, m_tdata[20:10]);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[9:0] !== want.index) begin
					$display("%0t: node_index mismatch, expected %0d actual %0d",
						$time, want.index, m_tdata[9:0]);
					err_count++;
				end
				if (m_tuser !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d",
						$time, want.status, m_tuser);
					err_count++;
				end
				if (m_tdata[20:10] !== want.count) begin
					$display("%0t: node_count mismatch, expected %0d actual %0d",
						$time, want.count, m_tdata[20:10]);
					err_count++;
				end
			end
		end
	end

	// sends one request, optionally after a gap; returns at the accepting edge
	// with tvalid still high so back-to-back requests need no second assignment
	task automatic send_item(input action_t act, input coord_t x, input coord_t y,
		input coord_t z);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= TDATA_W'({z, y, x});
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(snap_predict(act, x, y, z));
	endtask

	// sender holds off until every owed result has been taken
	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// radius changes only with the block idle
	task automatic set_radius(input logic [RADIUS_BITS-1:0] r);
		wait_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		radius_q     = r;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	function automatic coord_t random_coord();
		return coord_t'($urandom());
	endfunction

	// point within span of a cluster center on each axis
	function automatic coord_t jitter(int center, int span);
		int off;
		off = $urandom_range(0, span);
		if ($urandom_range(0, 1) == 1)
			off = -off;
		return coord_t'(center + off);
	endfunction

	// extremes of the coordinates, radius edge, ties, empty table, clear,
	// unused action and the radius extremes
	task automatic test_directed();
		coord_t cmax, cmin;
		cmax = coord_t'(8388607);
		cmin = coord_t'(-8388608);
		send_item(ACT_NEAREST, 0, 0, 0);             // nearest on an empty table
		send_item(ACT_NONE, cmax, cmin, cmax);       // unused action, empty table
		send_item(ACT_FIND, 0, 0, 0);                // first node
		send_item(ACT_FIND, 60, 80, 0);              // exactly on the radius
		send_item(ACT_FIND, 61, 80, 0);              // just outside it
		send_item(ACT_FIND, 200, 0, 0);
		send_item(ACT_FIND, 400, 0, 0);
		send_item(ACT_FIND, 300, 0, 0);              // tie, higher node wins
		send_item(ACT_NEAREST, 300, 0, 0);           // tie, lower node wins
		send_item(ACT_FIND, cmax, cmax, cmax);
		send_item(ACT_FIND, cmin, cmin, cmin);
		send_item(ACT_NEAREST, cmin, cmax, cmin);
		send_item(ACT_FIND, cmax, cmin, cmax);
		send_item(ACT_NONE, random_coord(), random_coord(), random_coord());
		send_item(ACT_CLEAR, cmax, cmax, cmax);
		send_item(ACT_NEAREST, 0, 0, 0);             // nearest after clear
		set_radius('0);
		send_item(ACT_FIND, 5, -5, 5);
		send_item(ACT_FIND, 5, -5, 5);               // exact hit with zero radius
		send_item(ACT_FIND, 5, -5, 6);
		send_item(ACT_NEAREST, 5, -5, 7);
		set_radius(RADIUS_MAX);
		send_item(ACT_FIND, cmin, cmin, cmin);       // beyond even the widest radius
		send_item(ACT_FIND, 1000, 1000, 1000);
		send_item(ACT_FIND, cmax, cmax, cmax);
		send_item(ACT_CLEAR, 0, 0, 0);
		set_radius(RADIUS_RESET);
	endtask

	// phases of clustered requests with fresh radius and centers; clears keep
	// the table short so most scans stay cheap
	task automatic test_random();
		int                     sent, kind, span, pick, c, burst;
		int                     centers[3];
		logic [RADIUS_BITS-1:0] r;
		action_t                act;
		coord_t                 x, y, z;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 5);
			case (kind)
				0:       r = '0;
				1:       r = RADIUS_BITS'($urandom_range(1, 20));
				2, 3:    r = RADIUS_BITS'($urandom_range(50, 3000));
				4:       r = RADIUS_BITS'($urandom_range(0, RADIUS_MAX));
				default: r = RADIUS_MAX;
			endcase
			set_radius(r);
			span = ((r < 2000) ? int'(r) : 2000) + 4;
			for (int k = 0; k < 3; k++)
				centers[k] = int'($urandom_range(0, 8000000)) - 4000000;
			burst = $urandom_range(25, 50);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				pick = $urandom_range(0, 99);
				if (pick < 58)
					act = ACT_FIND;
				else if (pick < 83)
					act = ACT_NEAREST;
				else if (pick < 91)
					act = ACT_CLEAR;
				else
					act = ACT_NONE;
				if ($urandom_range(0, 9) < 7) begin
					c = $urandom_range(0, 2);
					x = jitter(centers[c], span);
					y = jitter(centers[c], span);
					z = jitter(centers[c], span);
				end else begin
					x = random_coord();
					y = random_coord();
					z = random_coord();
				end
				quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
				send_item(act, x, y, z);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= ACT_FIND;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();

		// drain, then leave room for any stray result
		wait_results();
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
